>>> hdl/etbk_pkg.sv
// shared types, codes and constants of the epoch time base keeper
`default_nettype none
package etbk_pkg;

   localparam int MS_W    = 32;
   localparam int EPOCH_W = 32;
   localparam int MODE_W  = 2;
   localparam int SRC_W   = 2;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // item modes
   localparam logic [MODE_W-1:0] MODE_REPORT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EPOCH  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CIVIL  = 2'd2;

   // time sources
   localparam logic [SRC_W-1:0] SOURCE_NONE  = 2'd0;
   localparam logic [SRC_W-1:0] SOURCE_GPS   = 2'd1;
   localparam logic [SRC_W-1:0] SOURCE_MODEM = 2'd2;
   localparam logic [SRC_W-1:0] SOURCE_STALE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRESH_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPOCH_FLOOR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EPOCH_CEIL   = 2'd2;

   localparam logic [31:0] FRESH_WINDOW_RESET = 32'd60000;
   localparam logic [31:0] EPOCH_FLOOR_RESET  = 32'd1704067200;
   localparam logic [31:0] EPOCH_CEIL_RESET   = 32'd2871763200;

   // calendar constants
   localparam logic [31:0] DAYS_PER_ERA   = 32'd146097;
   localparam logic [31:0] EPOCH_DAY_OFS  = 32'd719468;
   localparam logic [31:0] YEARS_PER_ERA  = 32'd400;
   localparam logic [31:0] DAYS_PER_YEAR  = 32'd365;
   localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
   localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
   localparam logic [31:0] SECS_PER_MIN   = 32'd60;

   // reciprocal multipliers: y/400 = (y*20972)>>23 for y < 2^14,
   // yoe/100 = (yoe*656)>>16 for yoe < 400, x/1000 = (x*0x10624dd3)>>38
   localparam logic [31:0] RECIP_400  = 32'd20972;
   localparam int          SHIFT_400  = 23;
   localparam logic [31:0] RECIP_100  = 32'd656;
   localparam int          SHIFT_100  = 16;
   localparam logic [31:0] RECIP_1000 = 32'h10624dd3;
   localparam int          SHIFT_1000 = 38;

   // day of the march-based year on which a month starts, (153*mp+2)/5
   function automatic logic [8:0] month_start_day(input logic [MONTH_W-1:0] month);
      logic [8:0] d;
      case (month)
         4'd0:    d = 9'd275;
         4'd1:    d = 9'd306;
         4'd2:    d = 9'd337;
         4'd3:    d = 9'd0;
         4'd4:    d = 9'd31;
         4'd5:    d = 9'd61;
         4'd6:    d = 9'd92;
         4'd7:    d = 9'd122;
         4'd8:    d = 9'd153;
         4'd9:    d = 9'd184;
         4'd10:   d = 9'd214;
         4'd11:   d = 9'd245;
         4'd12:   d = 9'd275;
         4'd13:   d = 9'd306;
         4'd14:   d = 9'd337;
         default: d = 9'd367;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

>>> hdl/etbk_if.sv
// handshake channels of the epoch time base keeper
`default_nettype none
interface etbk_req_if import etbk_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MS_W-1:0]    ms_now;
   logic [MODE_W-1:0]  mode;
   logic [SRC_W-1:0]   source_in;
   logic [EPOCH_W-1:0] epoch_value;
   logic [YEAR_W-1:0]  year;
   logic [MONTH_W-1:0] month;
   logic [DAY_W-1:0]   day;
   logic [HOUR_W-1:0]  hour;
   logic [MIN_W-1:0]   minute;
   logic [SEC_W-1:0]   second;

   modport source (output valid, ms_now, mode, source_in, epoch_value, year, month, day,
                   hour, minute, second, input ready);
   modport sink (input valid, ms_now, mode, source_in, epoch_value, year, month, day,
                 hour, minute, second, output ready);
endinterface

interface etbk_rsp_if import etbk_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [EPOCH_W-1:0] epoch_now;
   logic [SRC_W-1:0]   source_out;

   modport source (output valid, epoch_now, source_out, input ready);
   modport sink (input valid, epoch_now, source_out, output ready);
endinterface

interface etbk_csr_if import etbk_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/epoch_time_base_keeper.sv
// epoch time base keeper: civil conversion, note filtering and epoch extrapolation
// a civil note steps through ERA, YOE, C100, DOE, ERAD, DAYS, HOUR, MIN, CHECK, DIV, OUT; an
//   epoch note through CHECK, DIV, OUT; others through DIV, OUT; new items wait for IDLE; the
//   arithmetic steps share one 32x32 multiplier, and a held result stalls the sequencer
// a finished result waits in the output register while the next item is taken
// reset: synchronous, restores register defaults and clears the base (source none)
`default_nettype none
module epoch_time_base_keeper import etbk_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   etbk_req_if.sink     req_bus,
   etbk_rsp_if.source   rsp_bus,
   etbk_csr_if.sink     csr_bus
);

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_ERA   = 12'b0000_0000_0010,
      ST_YOE   = 12'b0000_0000_0100,
      ST_C100  = 12'b0000_0000_1000,
      ST_DOE   = 12'b0000_0001_0000,
      ST_ERAD  = 12'b0000_0010_0000,
      ST_DAYS  = 12'b0000_0100_0000,
      ST_HOUR  = 12'b0000_1000_0000,
      ST_MIN   = 12'b0001_0000_0000,
      ST_CHECK = 12'b0010_0000_0000,
      ST_DIV   = 12'b0100_0000_0000,
      ST_OUT   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [31:0] fresh_window_ff, epoch_floor_ff, epoch_ceil_ff;

   // base
   logic [EPOCH_W-1:0] base_epoch_ff, base_epoch_in;
   logic [MS_W-1:0]    base_ms_ff, base_ms_in;
   logic [SRC_W-1:0]   base_src_ff, base_src_in;

   // latched item
   logic [MS_W-1:0]    ms_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic [SRC_W-1:0]   src_ff;
   logic [EPOCH_W-1:0] epoch_val_ff;
   logic signed [YEAR_W:0] y_ff;
   logic [MONTH_W-1:0] month_ff;
   logic [DAY_W-1:0]   day_ff;
   logic [HOUR_W-1:0]  hour_ff;
   logic [MIN_W-1:0]   min_ff;
   logic [SEC_W-1:0]   sec_ff;

   // working registers
   logic signed [6:0] era_ff, era_in;
   logic [8:0]        yoe_ff, yoe_in;
   logic [1:0]        c100_ff, c100_in;
   logic [31:0]       acc_ff, acc_in;

   // result register
   logic               rsp_valid_ff;
   logic [EPOCH_W-1:0] rsp_epoch_ff, rsp_epoch_in;
   logic [SRC_W-1:0]   rsp_src_ff, rsp_src_in;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;

   logic        req_xfer, rsp_xfer, out_go;
   logic        y_dec;
   logic [31:0] era_ext, y_ext, elapsed, note_epoch;
   logic        note_ok;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign rsp_xfer      = rsp_bus.valid && rsp_bus.ready;
   assign out_go        = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.epoch_now  = rsp_epoch_ff;
   assign rsp_bus.source_out = rsp_src_ff;

   assign y_dec   = (req_bus.month <= MONTH_W'(2));
   assign era_ext = {{25{era_ff[6]}}, era_ff};
   assign y_ext   = {{(32-YEAR_W-1){y_ff[YEAR_W]}}, y_ff};
   assign elapsed = ms_ff - base_ms_ff;
   assign prod    = 64'(mul_a) * 64'(mul_b);

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_ERA: begin
            mul_a = 32'(y_ff[YEAR_W-1:0]);
            mul_b = RECIP_400;
         end
         ST_YOE: begin
            mul_a = era_ext;
            mul_b = YEARS_PER_ERA;
         end
         ST_C100: begin
            mul_a = 32'(yoe_ff);
            mul_b = RECIP_100;
         end
         ST_DOE: begin
            mul_a = 32'(yoe_ff);
            mul_b = DAYS_PER_YEAR;
         end
         ST_ERAD: begin
            mul_a = era_ext;
            mul_b = DAYS_PER_ERA;
         end
         ST_DAYS: begin
            mul_a = acc_ff;
            mul_b = SECS_PER_DAY;
         end
         ST_HOUR: begin
            mul_a = 32'(hour_ff);
            mul_b = SECS_PER_HOUR;
         end
         ST_MIN: begin
            mul_a = 32'(min_ff);
            mul_b = SECS_PER_MIN;
         end
         ST_DIV: begin
            mul_a = elapsed;
            mul_b = RECIP_1000;
         end
         ST_IDLE, ST_CHECK, ST_OUT: begin
            mul_a = '0;
            mul_b = '0;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // note filter
   always_comb begin
      note_epoch = (mode_ff == MODE_CIVIL) ? acc_ff : epoch_val_ff;
      note_ok    = (mode_ff == MODE_EPOCH || mode_ff == MODE_CIVIL)
                && note_epoch >= epoch_floor_ff && note_epoch <= epoch_ceil_ff
                && (src_ff == SOURCE_GPS || src_ff == SOURCE_MODEM)
                && !(src_ff == SOURCE_MODEM && base_src_ff == SOURCE_GPS
                     && elapsed < fresh_window_ff);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      era_in        = era_ff;
      yoe_in        = yoe_ff;
      c100_in       = c100_ff;
      acc_in        = acc_ff;
      base_epoch_in = base_epoch_ff;
      base_ms_in    = base_ms_ff;
      base_src_in   = base_src_ff;
      rsp_epoch_in  = rsp_epoch_ff;
      rsp_src_in    = rsp_src_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_bus.mode == MODE_CIVIL) begin
                  state_in = ST_ERA;
               end else if (req_bus.mode == MODE_EPOCH) begin
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_ERA: begin
            // the only negative year is -1, which lies in era -1
            era_in   = y_ff[YEAR_W] ? -7'sd1 : $signed({1'b0, prod[SHIFT_400+5:SHIFT_400]});
            state_in = ST_YOE;
         end
         ST_YOE: begin
            yoe_in   = 9'(y_ext - prod[31:0]);
            state_in = ST_C100;
         end
         ST_C100: begin
            c100_in  = prod[SHIFT_100+1:SHIFT_100];
            state_in = ST_DOE;
         end
         ST_DOE: begin
            acc_in   = prod[31:0] + 32'(yoe_ff[8:2]) - 32'(c100_ff)
                     + 32'(month_start_day(month_ff)) + 32'(day_ff) - 32'd1 - EPOCH_DAY_OFS;
            state_in = ST_ERAD;
         end
         ST_ERAD: begin
            acc_in   = acc_ff + prod[31:0];
            state_in = ST_DAYS;
         end
         ST_DAYS: begin
            acc_in   = prod[31:0];
            state_in = ST_HOUR;
         end
         ST_HOUR: begin
            acc_in   = acc_ff + prod[31:0];
            state_in = ST_MIN;
         end
         ST_MIN: begin
            acc_in   = acc_ff + prod[31:0] + 32'(sec_ff);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (note_ok) begin
               base_epoch_in = note_epoch;
               base_ms_in    = ms_ff;
               base_src_in   = src_ff;
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            acc_in   = 32'(prod[63:SHIFT_1000]);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_go) begin
               if (base_src_ff == SOURCE_NONE) begin
                  rsp_epoch_in = '0;
                  rsp_src_in   = SOURCE_NONE;
               end else begin
                  rsp_epoch_in = base_epoch_ff + acc_ff;
                  rsp_src_in   = (elapsed < fresh_window_ff) ? base_src_ff : SOURCE_STALE;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         fresh_window_ff <= FRESH_WINDOW_RESET;
         epoch_floor_ff  <= EPOCH_FLOOR_RESET;
         epoch_ceil_ff   <= EPOCH_CEIL_RESET;
         base_epoch_ff   <= '0;
         base_ms_ff      <= '0;
         base_src_ff     <= SOURCE_NONE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_epoch_ff <= base_epoch_in;
         base_ms_ff    <= base_ms_in;
         base_src_ff   <= base_src_in;
         if (out_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            unique case (csr_bus.index)
               CSR_FRESH_WINDOW: fresh_window_ff <= csr_bus.data;
               CSR_EPOCH_FLOOR:  epoch_floor_ff  <= csr_bus.data;
               CSR_EPOCH_CEIL:   epoch_ceil_ff   <= csr_bus.data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ms_ff        <= req_bus.ms_now;
         mode_ff      <= req_bus.mode;
         src_ff       <= req_bus.source_in;
         epoch_val_ff <= req_bus.epoch_value;
         // january and february count with the previous year
         y_ff         <= $signed({1'b0, req_bus.year}) - $signed((YEAR_W+1)'(y_dec));
         month_ff     <= req_bus.month;
         day_ff       <= req_bus.day;
         hour_ff      <= req_bus.hour;
         min_ff       <= req_bus.minute;
         sec_ff       <= req_bus.second;
      end
      era_ff       <= era_in;
      yoe_ff       <= yoe_in;
      c100_ff      <= c100_in;
      acc_ff       <= acc_in;
      rsp_epoch_ff <= rsp_epoch_in;
      rsp_src_ff   <= rsp_src_in;
   end

endmodule
`default_nettype wire
